FILE: hdl/per_destination_message_coalescer_macros.svh
// Assertion macros for the per-destination message coalescer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PER_DESTINATION_MESSAGE_COALESCER_MACROS_SVH
`define PER_DESTINATION_MESSAGE_COALESCER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define PDMC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PDMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PDMC_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define PDMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/pdmc_pkg.sv
// Shared types and constants of the per-destination message coalescer.
// Used by the controller, the datapath and the top level; no dependencies.
package pdmc_pkg;

   localparam int DEST_W  = 4;
   localparam int SIZE_W  = 24;
   localparam int COUNT_W = 10;
   localparam int TOTAL_W = 25;
   localparam int ACT_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;

   // request operations
   localparam logic OP_INSERT    = 1'b0;
   localparam logic OP_FLUSH_ALL = 1'b1;

   // result actions
   localparam logic [ACT_W-1:0] ACT_DIRECT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SINGLE   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COMBINED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MESSAGES      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_SIZE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES         = 2'd2;

   // register reset values
   localparam logic [COUNT_W-1:0] MAX_MESSAGES_RST      = 10'd16;
   localparam logic [SIZE_W-1:0]  DIRECT_SIZE_LIMIT_RST = 24'd4096;
   localparam logic [SIZE_W-1:0]  MAX_BYTES_RST         = 24'd65536;

   typedef struct packed {
      logic              operation;
      logic [DEST_W-1:0] dest;
      logic [SIZE_W-1:0] message_size;
   } req_payload_type;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [DEST_W-1:0]  target;
      logic [COUNT_W-1:0] send_count;
      logic [TOTAL_W-1:0] byte_total;
      logic               last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_WALK
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;      // take the request and read its first entry
      logic ins_commit;   // write back the insert's entry update
      logic walk_step;    // clear the current walk entry and read the next one
      logic out_load;     // load the output register
      logic out_sel_walk; // output comes from the walk, not the insert
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_flush_all;
      logic ins_result;
      logic entry_occupied;
      logic walk_end;
      logic out_free;
   } status_type;

endpackage

FILE: hdl/pdmc_controller.sv
// Sequencing state machine of the message coalescer.
// Depends on pdmc_pkg and the assertion macro header.
`include "per_destination_message_coalescer_macros.svh"

module pdmc_controller
   import pdmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      req_take;

   assign req_take = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            // a flush-all item goes on to the walk
            if (status.op_flush_all) begin
               state_in = ST_WALK;
            end else if (!status.ins_result || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if ((!status.entry_occupied || status.out_free) && status.walk_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_take;
         end
         ST_INSERT: begin
            if (!status.op_flush_all) begin
               if (!status.ins_result) begin
                  cmd.ins_commit = 1'b1;
               end else if (status.out_free) begin
                  cmd.ins_commit = 1'b1;
                  cmd.out_load   = 1'b1;
               end
            end
         end
         ST_WALK: begin
            cmd.out_sel_walk = 1'b1;
            if (!status.entry_occupied) begin
               cmd.walk_step = 1'b1;
            end else if (status.out_free) begin
               cmd.walk_step = 1'b1;
               cmd.out_load  = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   `PDMC_ASSERT_NEXT(a_capture_leaves_idle, clock, reset, cmd.capture, state_ff != ST_IDLE, "capture did not leave idle")
   `PDMC_ASSERT_NEXT(a_walk_end_to_idle, clock, reset, (state_ff == ST_WALK) && cmd.walk_step && status.walk_end, state_ff == ST_IDLE, "walk did not finish at its last entry")
   `PDMC_ASSERT_IMP(a_load_needs_room, clock, reset, cmd.out_load, status.out_free, "output loaded without room")

endmodule

FILE: hdl/pdmc_datapath.sv
// Datapath of the message coalescer: request registers, per-destination
// pending table, configuration registers and the output register.
// Depends on pdmc_pkg and the assertion macro header.
`include "per_destination_message_coalescer_macros.svh"

module pdmc_datapath
   import pdmc_pkg::*;
#(
   parameter int NUM_DEST = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_payload_type       req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int IW = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;

   // configuration
   logic [COUNT_W-1:0] max_messages_ff;
   logic [SIZE_W-1:0]  direct_size_limit_ff;
   logic [SIZE_W-1:0]  max_bytes_ff;

   // request held for the duration of the item
   logic              op_ff;
   logic [DEST_W-1:0] dest_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              in_range_ff;
   logic [IW-1:0]     ptr_ff;

   // pending table; an entry whose occupancy bit is clear reads as empty
   logic [COUNT_W-1:0] cnt_mem   [NUM_DEST];
   logic [SIZE_W-1:0]  bytes_mem [NUM_DEST];
   logic [NUM_DEST-1:0] occ_ff;

   logic [COUNT_W-1:0] rd_cnt_ff;
   logic [SIZE_W-1:0]  rd_bytes_ff;
   logic               rd_valid_ff;

   logic            out_valid_ff;
   rsp_payload_type out_data_ff;

   logic               req_in_range;
   logic [IW-1:0]      req_addr;
   logic [IW-1:0]      next_ptr;
   logic [IW-1:0]      rd_addr;
   logic               rd_en;
   logic               walk_end;
   logic [COUNT_W-1:0] rd_cnt;
   logic [SIZE_W-1:0]  rd_bytes;
   logic [COUNT_W-1:0] cnt_new;
   logic [TOTAL_W-1:0] bytes_new;
   logic               ins_direct;
   logic               ins_flush;
   logic               ins_store;
   logic [NUM_DEST-1:0] occ_above;
   rsp_payload_type    ins_rsp;
   rsp_payload_type    walk_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_messages_ff      <= MAX_MESSAGES_RST;
         direct_size_limit_ff <= DIRECT_SIZE_LIMIT_RST;
         max_bytes_ff         <= MAX_BYTES_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_MESSAGES:      max_messages_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_DIRECT_SIZE_LIMIT: direct_size_limit_ff <= csr_wdata;
            CSR_MAX_BYTES:         max_bytes_ff         <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_in_range = int'(req_data.dest) < NUM_DEST;
   assign req_addr     = req_in_range ? IW'(req_data.dest) : '0;
   assign walk_end     = ptr_ff == IW'(NUM_DEST - 1);
   assign next_ptr     = walk_end ? '0 : ptr_ff + 1'b1;

   // flush-all starts its walk at entry 0
   assign rd_addr = cmd.capture ? ((req_data.operation == OP_FLUSH_ALL) ? '0 : req_addr)
                                : next_ptr;
   assign rd_en   = cmd.capture || cmd.walk_step;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_data.operation;
         dest_ff     <= req_data.dest;
         size_ff     <= req_data.message_size;
         in_range_ff <= req_in_range;
         ptr_ff      <= rd_addr;
      end else if (cmd.walk_step) begin
         ptr_ff <= next_ptr;
      end
   end

   // registered table read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_cnt_ff   <= cnt_mem[rd_addr];
         rd_bytes_ff <= bytes_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= occ_ff[rd_addr];
      end
   end

   assign rd_cnt   = rd_valid_ff ? rd_cnt_ff : '0;
   assign rd_bytes = rd_valid_ff ? rd_bytes_ff : '0;

   assign cnt_new    = rd_cnt + 1'b1;
   assign bytes_new  = {1'b0, rd_bytes} + {1'b0, size_ff};
   assign ins_direct = size_ff > direct_size_limit_ff;
   assign ins_flush  = (cnt_new >= max_messages_ff) || (bytes_new >= {1'b0, max_bytes_ff});
   assign ins_store  = in_range_ff && !ins_direct;

   always_ff @(posedge clock) begin
      if (cmd.ins_commit && ins_store && !ins_flush) begin
         cnt_mem[ptr_ff]   <= cnt_new;
         bytes_mem[ptr_ff] <= bytes_new[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.ins_commit && ins_store) begin
         occ_ff[ptr_ff] <= !ins_flush;
      end else if (cmd.walk_step) begin
         occ_ff[ptr_ff] <= 1'b0;
      end
   end

   // entries past the walk position that still hold messages
   always_comb begin
      for (int i = 0; i < NUM_DEST; i++) begin
         occ_above[i] = occ_ff[i] && (IW'(i) > ptr_ff);
      end
   end

   always_comb begin
      ins_rsp.target = dest_ff;
      ins_rsp.last   = 1'b1;
      if (ins_direct) begin
         ins_rsp.action     = ACT_DIRECT;
         ins_rsp.send_count = COUNT_W'(1);
         ins_rsp.byte_total = {1'b0, size_ff};
      end else begin
         ins_rsp.action     = (cnt_new == COUNT_W'(1)) ? ACT_SINGLE : ACT_COMBINED;
         ins_rsp.send_count = cnt_new;
         ins_rsp.byte_total = bytes_new;
      end
   end

   always_comb begin
      walk_rsp.action     = (rd_cnt == COUNT_W'(1)) ? ACT_SINGLE : ACT_COMBINED;
      walk_rsp.target     = DEST_W'(ptr_ff);
      walk_rsp.send_count = rd_cnt;
      walk_rsp.byte_total = {1'b0, rd_bytes};
      walk_rsp.last       = ~|occ_above;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= cmd.out_sel_walk ? walk_rsp : ins_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign status.op_flush_all   = op_ff == OP_FLUSH_ALL;
   assign status.ins_result     = in_range_ff && (ins_direct || ins_flush);
   assign status.entry_occupied = rd_valid_ff;
   assign status.walk_end       = walk_end;
   assign status.out_free       = !out_valid_ff || !rsp_stall;

   `PDMC_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !out_valid_ff || !rsp_stall, "pending transfer overwritten")
   `PDMC_ASSERT_IMP(a_count_nonzero, clock, reset, out_valid_ff, out_data_ff.send_count != '0, "result with zero messages")
   `PDMC_ASSERT_IMP(a_occupied_nonempty, clock, reset, rd_valid_ff, rd_cnt_ff != '0, "occupied entry read with zero count")

endmodule

FILE: hdl/per_destination_message_coalescer.sv
// Insert: accepted in idle; a direct or flush result is loaded into the output register once it is free,
// and the next item is taken after that. Flush-all: walks every destination one per cycle, waiting at a
// non-empty one for output room, one result per non-empty destination; the next item follows the walk.
// Output register lets a new item start while a result waits for transfer.
// Synchronous reset empties all destinations at once (per-entry occupancy flags)
// and restores max_messages 16, direct_size_limit 4096, max_bytes 65536.
module per_destination_message_coalescer
   import pdmc_pkg::*;
#(
   parameter int NUM_DEST = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   pdmc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pdmc_datapath #(
      .NUM_DEST (NUM_DEST)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: tb/sv/tb_per_destination_message_coalescer.sv
// Self-checking testbench for the per-destination message coalescer.
// Needs pdmc_pkg and the coalescer RTL; a scoreboard class predicts every send.
module tb_per_destination_message_coalescer;
   import pdmc_pkg::*;

   localparam int NUM_DEST = 16;
   localparam int DRAIN_CYCLES = 2 * NUM_DEST + 4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   class send_predictor;
      int num_dest;
      logic [COUNT_W-1:0] max_messages;
      logic [SIZE_W-1:0]  direct_limit;
      logic [SIZE_W-1:0]  max_bytes;
      logic [COUNT_W-1:0] pend_count [1 << DEST_W];
      logic [SIZE_W-1:0]  pend_bytes [1 << DEST_W];
      rsp_payload_type    expected_sends [$];

      function new(int n);
         num_dest = n;
         max_messages = MAX_MESSAGES_RST;
         direct_limit = DIRECT_SIZE_LIMIT_RST;
         max_bytes = MAX_BYTES_RST;
         for (int d = 0; d < (1 << DEST_W); d++) begin
            pend_count[d] = '0;
            pend_bytes[d] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_MAX_MESSAGES:      max_messages = val[COUNT_W-1:0];
            CSR_DIRECT_SIZE_LIMIT: direct_limit = val[SIZE_W-1:0];
            CSR_MAX_BYTES:         max_bytes = val[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function void push_send(logic [ACT_W-1:0] act, logic [DEST_W-1:0] d,
                              logic [COUNT_W-1:0] cnt, logic [TOTAL_W-1:0] bytes, logic fin);
         rsp_payload_type s;
         s.action = act;
         s.target = d;
         s.send_count = cnt;
         s.byte_total = bytes;
         s.last = fin;
         expected_sends.push_back(s);
      endfunction

      function void note_request(req_payload_type req);
         logic [COUNT_W:0]   cnt;
         logic [TOTAL_W-1:0] sum;
         int remaining;
         if (req.operation == OP_FLUSH_ALL) begin
            remaining = 0;
            for (int d = 0; d < num_dest; d++)
               if (pend_count[d] != 0) remaining++;
            for (int d = 0; d < num_dest; d++) begin
               if (pend_count[d] != 0) begin
                  remaining--;
                  push_send(pend_count[d] == 1 ? ACT_SINGLE : ACT_COMBINED, DEST_W'(d),
                            pend_count[d], {1'b0, pend_bytes[d]}, remaining == 0);
                  pend_count[d] = '0;
                  pend_bytes[d] = '0;
               end
            end
         end else if (req.dest < num_dest) begin
            if (req.message_size > direct_limit) begin
               push_send(ACT_DIRECT, req.dest, COUNT_W'(1), {1'b0, req.message_size}, 1'b1);
            end else begin
               cnt = {1'b0, pend_count[req.dest]} + 1'b1;
               sum = {1'b0, pend_bytes[req.dest]} + {1'b0, req.message_size};
               if (cnt >= max_messages || sum >= max_bytes) begin
                  push_send(cnt == 1 ? ACT_SINGLE : ACT_COMBINED, req.dest,
                            cnt[COUNT_W-1:0], sum, 1'b1);
                  pend_count[req.dest] = '0;
                  pend_bytes[req.dest] = '0;
               end else begin
                  pend_count[req.dest] = cnt[COUNT_W-1:0];
                  pend_bytes[req.dest] = sum[SIZE_W-1:0];
               end
            end
         end
      endfunction

      // Empty string when the send matches the oldest expected one.
      function string check_send(rsp_payload_type got);
         rsp_payload_type want;
         string diffs;
         if (expected_sends.size() == 0)
            return $sformatf("unexpected send action %0d target %0d count %0d bytes %0d",
                             got.action, got.target, got.send_count, got.byte_total);
         want = expected_sends.pop_front();
         diffs = "";
         if (got.action !== want.action)
            diffs = {diffs, $sformatf(" action %0d exp %0d", got.action, want.action)};
         if (got.target !== want.target)
            diffs = {diffs, $sformatf(" target %0d exp %0d", got.target, want.target)};
         if (got.send_count !== want.send_count)
            diffs = {diffs, $sformatf(" count %0d exp %0d", got.send_count, want.send_count)};
         if (got.byte_total !== want.byte_total)
            diffs = {diffs, $sformatf(" bytes %0d exp %0d", got.byte_total, want.byte_total)};
         if (got.last !== want.last)
            diffs = {diffs, $sformatf(" last %0d exp %0d", got.last, want.last)};
         if (diffs != "")
            diffs = {$sformatf("send to %0d:", want.target), diffs};
         return diffs;
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   send_predictor sends = new(NUM_DEST);
   int  fail_count = 0;
   bit  no_idle = 0;
   string diff_msg;

   per_destination_message_coalescer #(.NUM_DEST(NUM_DEST)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sends.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         diff_msg = sends.check_send(rsp_data);
         if (diff_msg != "") report_mismatch(diff_msg);
      end
   end

   initial begin
      int run_len;
      int stall_len;
      rsp_stall = 1'b0;
      forever begin
         run_len = $urandom_range(8, 1);
         repeat (run_len) @(negedge clock) rsp_stall = 1'b0;
         stall_len = pick_gap();
         repeat (stall_len) @(negedge clock) rsp_stall = 1'b1;
      end
   end

   task automatic send_request(input logic op, input logic [DEST_W-1:0] d,
                               input logic [SIZE_W-1:0] sz);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = '{operation: op, dest: d, message_size: sz};
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic insert(input logic [DEST_W-1:0] d, input logic [SIZE_W-1:0] sz);
      send_request(OP_INSERT, d, sz);
   endtask

   task automatic flush_all();
      send_request(OP_FLUSH_ALL, DEST_W'($urandom_range(15)), SIZE_W'($urandom));
   endtask

   // Drop valid, drain every expected send, then let a silent walk finish.
   task automatic wait_idle();
      @(negedge clock) req_valid = 1'b0;
      while (sends.expected_sends.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      sends.write_reg(idx, val);
      @(negedge clock) csr_valid = 1'b0;
   endtask

   task automatic configure(input logic [COUNT_W-1:0] mm, input logic [SIZE_W-1:0] dl,
                            input logic [SIZE_W-1:0] mb);
      wait_idle();
      csr_write(CSR_MAX_MESSAGES, CSR_DATA_W'(mm));
      csr_write(CSR_DIRECT_SIZE_LIMIT, dl);
      csr_write(CSR_MAX_BYTES, mb);
      no_idle = ($urandom_range(3) == 0);
   endtask

   task automatic run_random(input int n);
      int unsigned r;
      int unsigned hi;
      int unsigned sz;
      logic [DEST_W-1:0] d;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            flush_all();
         end else begin
            // favor a few destinations so batches build up
            d = ($urandom_range(99) < 60) ? DEST_W'($urandom_range(3))
                                          : DEST_W'($urandom_range(15));
            r = $urandom_range(99);
            if (r < 10) sz = 0;
            else if (r < 18) sz = 32'(sends.direct_limit);
            else if (r < 26) sz = 32'(sends.direct_limit) + 1;
            else if (r < 34) sz = $urandom & 24'hFFFFFF;
            else begin
               hi = 32'(sends.max_bytes >> 2);
               if (sends.direct_limit < hi) hi = 32'(sends.direct_limit);
               sz = $urandom_range(hi, 0);
            end
            insert(d, sz[SIZE_W-1:0]);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // reset limits: zero size, direct sends at the boundary, flush-all
      insert(4'd0, 24'd0);
      insert(4'd15, 24'hFFFFFF);
      insert(4'd15, 24'd4096);
      insert(4'd15, 24'd4097);
      insert(4'd9, 24'd1000);
      insert(4'd9, 24'd2000);
      flush_all();
      flush_all();
      run_random(20);

      // zero flush limits: every buffered insert leaves at once
      configure(10'd0, 24'hFFFFFF, 24'd0);
      insert(4'd2, 24'd0);
      insert(4'd2, 24'hFFFFFF);
      run_random(15);

      // widest limits: pending sum carries into the 25th bit
      configure(10'd1023, 24'hFFFFFF, 24'hFFFFFF);
      insert(4'd6, 24'hFFFFFE);
      insert(4'd6, 24'hFFFFFF);
      insert(4'd6, 24'hFFFFFF);
      run_random(20);
      insert(4'd11, 24'd500);
      insert(4'd12, 24'd700);

      // lower limits while messages wait
      configure(10'd4, 24'd100, 24'd200);
      insert(4'd11, 24'd50);
      insert(4'd12, 24'd101);
      repeat (4) insert(4'd13, 24'd1);
      flush_all();
      run_random(20);

      configure(10'd16, 24'd0, 24'd0);
      run_random(15);

      configure(COUNT_W'($urandom_range(1023)), SIZE_W'($urandom), SIZE_W'($urandom));
      csr_write(CSR_UNUSED, CSR_DATA_W'($urandom));
      run_random(15);

      configure(10'd8, 24'd2048, 24'd16384);
      run_random(20);

      wait_idle();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pdmc_pkg.sv
hdl/pdmc_controller.sv
hdl/pdmc_datapath.sv
hdl/per_destination_message_coalescer.sv
tb/sv/tb_per_destination_message_coalescer.sv
